FILE: sv/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared forms for the concurrent checks of the LED packet parser.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: sv/clpp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clpp_pkg
// Types, codes and helpers shared by the chunked LED packet parser.
// ----------------------------------------------------------------------------
package clpp_pkg;

    typedef enum logic [2:0] {
        ST_NONE  = 3'd0,
        ST_OK    = 3'd1,
        ST_SHORT = 3'd2,
        ST_ENC   = 3'd3,
        ST_MOD3  = 3'd4
    } status_t;

    localparam logic [7:0]  ENC_RGB         = 8'd4;
    localparam logic [10:0] HDR_BYTES       = 11'd3;
    localparam logic [15:0] LED_COUNT_RESET = 16'd600;

    typedef struct packed {
        logic [4:0]  pad;
        logic [10:0] packet_length;
        logic [7:0]  data_byte;
    } item_t;

    typedef struct packed {
        logic [1:0]  pad;
        logic [2:0]  packet_status;
        logic [7:0]  missed_count;
        logic        gap_seen;
        logic        frame_ready;
        logic [7:0]  blue;
        logic [7:0]  green;
        logic [7:0]  red;
        logic [15:0] pixel_index;
        logic        pixel_write;
    } result_t;

    // Remainder by three is zero, using base-four digit sums.
    function automatic logic mod3_zero(input logic [10:0] v);
        logic [11:0] w;
        logic [4:0]  s1;
        logic [5:0]  w2;
        logic [3:0]  s2;
        w  = {1'b0, v};
        s1 = '0;
        for (int i = 0; i < 6; i++)
        begin
            s1 = s1 + 5'(w[2*i +: 2]);
        end
        w2 = {1'b0, s1};
        s2 = 4'(w2[1:0]) + 4'(w2[3:2]) + 4'(w2[5:4]);
        return (s2 == 4'd0) || (s2 == 4'd3) || (s2 == 4'd6) || (s2 == 4'd9);
    endfunction

endpackage

FILE: sv/chunked_led_packet_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chunked_led_packet_parser
// Parses chunked LED datagrams byte by byte into pixel writes and status.
// ----------------------------------------------------------------------------
// Channel       Dir  Payload
// s_axis_*      in   tdata: data_byte[7:0], packet_length[18:8]
// m_axis_*      out  tdata: pixel_write, pixel_index, red, green, blue,
//                    frame_ready, gap_seen, missed_count, packet_status
// cfg_*         in   led_count write, no read-back
//
// One byte is taken per cycle unless the output stalls; each result passes through
// one register stage for the input and one for the result.
// The input register frees whenever the result register can load, so a stalled
// output blocks input only once both stages are full.
// Reset is asynchronous and clears all packet and sequence state; led_count
// returns to 600.
// ----------------------------------------------------------------------------
module chunked_led_packet_parser
    import clpp_pkg::*;
#(
    parameter int CHUNK_PIXELS     = 300,
    parameter int MAX_PACKET_BYTES = 1472
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // data_byte[7:0], packet_length[18:8]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [55:0] m_axis_tdata,   // pixel_write[0], pixel_index[16:1],
                                        // red[24:17], green[32:25], blue[40:33],
                                        // frame_ready[41], gap_seen[42],
                                        // missed_count[50:43], packet_status[53:51]
    input  logic        cfg_we,
    input  logic [15:0] cfg_wdata
);

    logic    item_valid;
    item_t   item;
    logic    take;
    result_t result;

    clpp_in_reg u_in_reg
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .take          (take),
        .item_valid    (item_valid),
        .item          (item)
    );

    clpp_parse #(
        .CHUNK_PIXELS     (CHUNK_PIXELS),
        .MAX_PACKET_BYTES (MAX_PACKET_BYTES)
    ) u_parse
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .item_fire (take),
        .item      (item),
        .result    (result)
    );

    clpp_out_reg u_out_reg
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .item_valid    (item_valid),
        .result        (result),
        .take          (take),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

endmodule

FILE: sv/clpp_in_reg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clpp_in_reg
// Input register stage of the parser.
// ----------------------------------------------------------------------------
module clpp_in_reg
    import clpp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,
    input  logic        take,
    output logic        item_valid,
    output item_t       item
);

    logic  valid_reg;
    logic  valid_next;
    item_t item_reg;

    assign s_axis_tready = !valid_reg || take;

    always_comb
    begin
        valid_next = valid_reg;
        if (s_axis_tvalid && s_axis_tready)
        begin
            valid_next = 1'b1;
        end
        else if (take)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            item_reg <= item_t'(s_axis_tdata);
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

FILE: sv/clpp_parse.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"
// ----------------------------------------------------------------------------
// clpp_parse
// Packet state and per-byte decode: sequence, header checks, pixel writes.
// ----------------------------------------------------------------------------
module clpp_parse
    import clpp_pkg::*;
#(
    parameter int CHUNK_PIXELS     = 300,
    parameter int MAX_PACKET_BYTES = 1472
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [15:0] cfg_wdata,
    input  logic        item_fire,
    input  item_t       item,
    output result_t     result
);

    localparam int PIX_W   = $clog2(MAX_PACKET_BYTES / 3 + 1);
    localparam int IDX_RAW = $clog2(258 * CHUNK_PIXELS + MAX_PACKET_BYTES / 3 + 1);
    localparam int IDX_W   = (IDX_RAW > 16) ? IDX_RAW : 17;

    logic [15:0]      led_count_reg;
    logic [10:0]      offset_reg,   offset_next;
    logic             seen_reg,     seen_next;
    logic [7:0]       expect_reg,   expect_next;
    logic             sent_reg,     sent_next;
    status_t          verdict_reg,  verdict_next;
    logic [1:0]       phase_reg,    phase_next;
    logic [15:0]      held_reg,     held_next;
    logic [PIX_W-1:0] pix_reg,      pix_next;
    logic             stop_reg,     stop_next;
    logic [IDX_W-1:0] base_reg,     base_next;
    logic [IDX_W-1:0] last_lo_reg,  last_lo_next;
    logic [IDX_W-1:0] last_hi_reg,  last_hi_next;

    logic [10:0]      len_sat;
    logic             last;
    logic [7:0]       seq_ref;
    logic [IDX_W-1:0] idx;
    logic [IDX_W-1:0] led_wide;
    logic             last_chunk;
    status_t          status;

    assign len_sat  = (item.packet_length > 11'(MAX_PACKET_BYTES)) ?
                      11'(MAX_PACKET_BYTES) : item.packet_length;
    assign last     = ({1'b0, offset_reg} + 12'd1) >= {1'b0, len_sat};
    assign seq_ref  = seen_reg ? expect_reg : item.data_byte;
    assign idx      = base_reg + IDX_W'(pix_reg);
    assign led_wide = IDX_W'(led_count_reg);
    assign last_chunk = (led_wide >= last_lo_reg) && (led_wide < last_hi_reg);

    always_comb
    begin
        offset_next  = offset_reg + 11'd1;
        seen_next    = seen_reg;
        expect_next  = expect_reg;
        sent_next    = sent_reg;
        verdict_next = verdict_reg;
        phase_next   = phase_reg;
        held_next    = held_reg;
        pix_next     = pix_reg;
        stop_next    = stop_reg;
        base_next    = base_reg;
        last_lo_next = last_lo_reg;
        last_hi_next = last_hi_reg;
        status       = ST_NONE;
        result       = '0;

        if (len_sat < HDR_BYTES)
        begin
            if (offset_reg == 11'd0)
            begin
                verdict_next = ST_SHORT;
            end
        end
        else if (offset_reg == 11'd0)
        begin
            seen_next = 1'b1;
            if (seq_ref != item.data_byte)
            begin
                result.gap_seen     = 1'b1;
                result.missed_count = item.data_byte - seq_ref;
            end
            expect_next = item.data_byte + 8'd1;
        end
        else if (offset_reg == 11'd1)
        begin
            base_next    = IDX_W'(item.data_byte) * IDX_W'(CHUNK_PIXELS);
            last_lo_next = base_next + IDX_W'(CHUNK_PIXELS);
            last_hi_next = last_lo_next + IDX_W'(CHUNK_PIXELS);
            if (item.data_byte == 8'd0)
            begin
                if (!sent_reg)
                begin
                    result.frame_ready = 1'b1;
                end
                else
                begin
                    sent_next = 1'b0;
                end
            end
        end
        else if (offset_reg == 11'd2)
        begin
            if (item.data_byte != ENC_RGB)
            begin
                verdict_next = ST_ENC;
            end
            else if (!mod3_zero(len_sat))
            begin
                verdict_next = ST_MOD3;
            end
            else
            begin
                verdict_next = ST_OK;
            end
        end
        else if (verdict_reg == ST_OK)
        begin
            unique case (phase_reg)
                2'd0:
                begin
                    held_next  = {item.data_byte, 8'd0};
                    phase_next = 2'd1;
                end
                2'd1:
                begin
                    held_next  = {held_reg[15:8], item.data_byte};
                    phase_next = 2'd2;
                end
                default:
                begin
                    phase_next = 2'd0;
                    pix_next   = pix_reg + PIX_W'(1);
                    if (!stop_reg)
                    begin
                        if (idx >= led_wide)
                        begin
                            stop_next = 1'b1;
                        end
                        else
                        begin
                            result.pixel_write = 1'b1;
                            result.pixel_index = idx[15:0];
                            result.red         = held_reg[15:8];
                            result.green       = held_reg[7:0];
                            result.blue        = item.data_byte;
                        end
                    end
                end
            endcase
        end

        if (last)
        begin
            status = (verdict_next == ST_NONE) ? ST_SHORT : verdict_next;
            if ((status == ST_OK) && last_chunk)
            begin
                result.frame_ready = 1'b1;
                sent_next          = 1'b1;
            end
            offset_next  = '0;
            verdict_next = ST_NONE;
            phase_next   = '0;
            held_next    = '0;
            pix_next     = '0;
            stop_next    = 1'b0;
        end
        result.packet_status = status;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            led_count_reg <= LED_COUNT_RESET;
        end
        else if (cfg_we)
        begin
            led_count_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_reg  <= '0;
            seen_reg    <= 1'b0;
            expect_reg  <= '0;
            sent_reg    <= 1'b0;
            verdict_reg <= ST_NONE;
            phase_reg   <= '0;
            held_reg    <= '0;
            pix_reg     <= '0;
            stop_reg    <= 1'b0;
            base_reg    <= '0;
            last_lo_reg <= IDX_W'(CHUNK_PIXELS);
            last_hi_reg <= IDX_W'(2 * CHUNK_PIXELS);
        end
        else if (item_fire)
        begin
            offset_reg  <= offset_next;
            seen_reg    <= seen_next;
            expect_reg  <= expect_next;
            sent_reg    <= sent_next;
            verdict_reg <= verdict_next;
            phase_reg   <= phase_next;
            held_reg    <= held_next;
            pix_reg     <= pix_next;
            stop_reg    <= stop_next;
            base_reg    <= base_next;
            last_lo_reg <= last_lo_next;
            last_hi_reg <= last_hi_next;
        end
    end

    `ASSERT_SAME(a_write_needs_ok, clk, rst_n, item_fire && result.pixel_write, (verdict_reg == ST_OK) && (phase_reg == 2'd2), "pixel write outside an accepted packet")
    `ASSERT_SAME(a_gap_on_seq_byte, clk, rst_n, item_fire && result.gap_seen, offset_reg == 11'd0, "gap reported away from the sequence byte")
    `ASSERT_NEXT(a_last_clears, clk, rst_n, item_fire && last, (offset_reg == 11'd0) && (verdict_reg == ST_NONE), "packet state not cleared after last byte")

endmodule

FILE: sv/clpp_out_reg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clpp_out_reg
// Result register stage driving the output stream.
// ----------------------------------------------------------------------------
module clpp_out_reg
    import clpp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        item_valid,
    input  result_t     result,
    output logic        take,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [55:0] m_axis_tdata
);

    logic    valid_reg;
    logic    valid_next;
    result_t data_reg;

    assign take = item_valid && (!valid_reg || m_axis_tready);

    always_comb
    begin
        valid_next = valid_reg;
        if (take)
        begin
            valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            data_reg <= result;
        end
    end

    assign m_axis_tvalid = valid_reg;
    assign m_axis_tdata  = data_reg;

endmodule

FILE: tb/clpp_scoreboard.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clpp_scoreboard
// Watches the byte stream going into the chunked LED packet parser and the
// result stream coming out of it. Each input transfer is parsed by a local
// copy of the parser state to form the expected result, and every result
// transfer is compared field by field with the oldest expected one.
// ----------------------------------------------------------------------------
module clpp_scoreboard
    import clpp_pkg::*;
#(
    parameter int CHUNK_PIXELS     = 300,
    parameter int MAX_PACKET_BYTES = 1472
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [55:0] m_axis_tdata,
    input  logic        cfg_we,
    input  logic [15:0] cfg_wdata,
    output int          failures,
    output int          pending
);

    logic [15:0] led_count;
    logic [10:0] byte_offset;
    logic        seen_first;
    logic [7:0]  expected_seq;
    logic [7:0]  chunk_number;
    logic        frame_sent;
    status_t     verdict;
    logic [1:0]  color_phase;
    logic [15:0] held_rg;
    logic [8:0]  pixel_in_packet;
    logic        writes_stopped;
    result_t     expected_results[$];

    task automatic report_error(input string what, input int got, input int want);
        failures++;
        $display("%0t error: %s got %0d expected %0d", $realtime, what, got, want);
    endtask

    function automatic logic is_strip_end(input logic [7:0] chunk);
        int q;
        q = int'(led_count) / CHUNK_PIXELS;
        return (q != 0) && (int'(chunk) == q - 1);
    endfunction

    function automatic void clear_packet();
        byte_offset     = '0;
        verdict         = ST_NONE;
        color_phase     = '0;
        held_rg         = '0;
        pixel_in_packet = '0;
        writes_stopped  = 1'b0;
    endfunction

    function automatic result_t parse_byte(input item_t it);
        result_t r;
        int      len;
        int      idx;
        logic    last;
        r   = '0;
        len = int'(it.packet_length);
        if (len > MAX_PACKET_BYTES)
        begin
            len = MAX_PACKET_BYTES;
        end
        last = (int'(byte_offset) + 1 >= len);

        if (len < int'(HDR_BYTES))
        begin
            if (byte_offset == 0)
            begin
                verdict = ST_SHORT;
            end
        end
        else if (byte_offset == 0)
        begin
            if (!seen_first)
            begin
                seen_first   = 1'b1;
                expected_seq = it.data_byte;
            end
            if (expected_seq != it.data_byte)
            begin
                r.gap_seen     = 1'b1;
                r.missed_count = it.data_byte - expected_seq;
            end
            expected_seq = it.data_byte + 8'd1;
        end
        else if (byte_offset == 1)
        begin
            chunk_number = it.data_byte;
            if (it.data_byte == 8'd0)
            begin
                if (!frame_sent)
                begin
                    r.frame_ready = 1'b1;
                end
                else
                begin
                    frame_sent = 1'b0;
                end
            end
        end
        else if (byte_offset == 2)
        begin
            if (it.data_byte != ENC_RGB)
            begin
                verdict = ST_ENC;
            end
            else if ((len - int'(HDR_BYTES)) % 3 != 0)
            begin
                verdict = ST_MOD3;
            end
            else
            begin
                verdict = ST_OK;
            end
        end
        else if (verdict == ST_OK)
        begin
            if (color_phase == 2'd0)
            begin
                held_rg     = {it.data_byte, 8'd0};
                color_phase = 2'd1;
            end
            else if (color_phase == 2'd1)
            begin
                held_rg[7:0] = it.data_byte;
                color_phase  = 2'd2;
            end
            else
            begin
                idx         = int'(chunk_number) * CHUNK_PIXELS + int'(pixel_in_packet);
                color_phase = 2'd0;
                if (!writes_stopped)
                begin
                    if (idx >= int'(led_count))
                    begin
                        writes_stopped = 1'b1;
                    end
                    else
                    begin
                        r.pixel_write = 1'b1;
                        r.pixel_index = 16'(idx);
                        r.red         = held_rg[15:8];
                        r.green       = held_rg[7:0];
                        r.blue        = it.data_byte;
                    end
                end
                pixel_in_packet = pixel_in_packet + 9'd1;
            end
        end

        if (last)
        begin
            r.packet_status = (verdict == ST_NONE) ? ST_SHORT : verdict;
            if (r.packet_status == ST_OK && is_strip_end(chunk_number))
            begin
                r.frame_ready = 1'b1;
                frame_sent    = 1'b1;
            end
            clear_packet();
        end
        else
        begin
            byte_offset = byte_offset + 11'd1;
        end
        return r;
    endfunction

    task automatic check_result(input result_t got);
        result_t want;
        if (expected_results.size() == 0)
        begin
            report_error("result with none outstanding, pixel_index", got.pixel_index, 0);
            return;
        end
        want = expected_results.pop_front();
        if (got.pixel_write != want.pixel_write)
            report_error("pixel_write", got.pixel_write, want.pixel_write);
        if (got.pixel_index != want.pixel_index)
            report_error("pixel_index", got.pixel_index, want.pixel_index);
        if (got.red != want.red)
            report_error("red", got.red, want.red);
        if (got.green != want.green)
            report_error("green", got.green, want.green);
        if (got.blue != want.blue)
            report_error("blue", got.blue, want.blue);
        if (got.frame_ready != want.frame_ready)
            report_error("frame_ready", got.frame_ready, want.frame_ready);
        if (got.gap_seen != want.gap_seen)
            report_error("gap_seen", got.gap_seen, want.gap_seen);
        if (got.missed_count != want.missed_count)
            report_error("missed_count", got.missed_count, want.missed_count);
        if (got.packet_status != want.packet_status)
            report_error("packet_status", got.packet_status, want.packet_status);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            failures     = 0;
            led_count    = LED_COUNT_RESET;
            seen_first   = 1'b0;
            expected_seq = '0;
            chunk_number = '0;
            frame_sent   = 1'b0;
            clear_packet();
            expected_results.delete();
        end
        else
        begin
            if (cfg_we)
            begin
                led_count = cfg_wdata;
            end
            if (m_axis_tvalid && m_axis_tready)
            begin
                check_result(result_t'(m_axis_tdata));
            end
            if (s_axis_tvalid && s_axis_tready)
            begin
                expected_results.push_back(parse_byte(item_t'(s_axis_tdata)));
            end
        end
        pending = expected_results.size();
    end

endmodule

FILE: tb/chunked_led_packet_parser_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chunked_led_packet_parser_tb
// Drives LED datagrams into the packet parser byte by byte: a few hand-built
// packets covering short, gapped, mis-encoded and misaligned cases, then
// phases of mostly well-formed random packets at several strip lengths.
// Both stream sides stall at random; a scoreboard module checks every result.
// ----------------------------------------------------------------------------
module chunked_led_packet_parser_tb;
    import clpp_pkg::*;

    localparam int CHUNK_PIXELS     = 300;
    localparam int MAX_PACKET_BYTES = 1472;
    localparam int NO_SWITCH        = 4096;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [55:0] m_axis_tdata;
    logic        cfg_we;
    logic [15:0] cfg_wdata;
    int          failures;
    int          pending;

    logic        quiet;
    logic        idle_on;
    logic        rx_calm;
    logic        hold_request;
    logic [7:0]  next_seq;
    logic [15:0] led_now;
    int          sent_items;

    chunked_led_packet_parser #(
        .CHUNK_PIXELS    (CHUNK_PIXELS),
        .MAX_PACKET_BYTES(MAX_PACKET_BYTES)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata)
    );

    clpp_scoreboard #(
        .CHUNK_PIXELS    (CHUNK_PIXELS),
        .MAX_PACKET_BYTES(MAX_PACKET_BYTES)
    ) scoreboard (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .failures     (failures),
        .pending      (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #20_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Result side: random stalls, calm stretches, and one long hold on request.
    initial
    begin
        int   stall;
        logic hold_done;
        rx_calm       = 1'b0;
        hold_done     = 1'b0;
        m_axis_tready = 1'b0;
        forever
        begin
            if (hold_request && !hold_done)
            begin
                hold_done = 1'b1;
                m_axis_tready <= 1'b0;
                stall = 400;
            end
            else if (!quiet && !rx_calm && $urandom_range(0, 7) == 0)
            begin
                m_axis_tready <= 1'b0;
                stall = $urandom_range(1, 15);
            end
            else
            begin
                m_axis_tready <= 1'b1;
                stall = 1;
                if ($urandom_range(0, 99) == 0)
                begin
                    rx_calm = ~rx_calm;
                end
            end
            repeat (stall) @(posedge clk);
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic [10:0] len);
        item_t it;
        it               = '0;
        it.data_byte     = b;
        it.packet_length = len;
        s_axis_tdata  <= it;
        s_axis_tvalid <= 1'b1;
        @(posedge clk);
        while (!s_axis_tready)
        begin
            @(posedge clk);
        end
        sent_items++;
        if (!quiet && idle_on && $urandom_range(0, 7) == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge clk);
        end
    endtask

    // The byte count follows the length each byte carries, as the parser does.
    task automatic send_packet(input logic [7:0] seq, input logic [7:0] chunk,
                               input logic [7:0] enc, input logic [10:0] len,
                               input logic [10:0] alt_len, input int switch_at);
        int          i;
        int          eff;
        logic [10:0] l;
        logic [7:0]  b;
        i = 0;
        while (1)
        begin
            l   = (i < switch_at) ? len : alt_len;
            eff = (int'(l) > MAX_PACKET_BYTES) ? MAX_PACKET_BYTES : int'(l);
            case (i)
                0:       b = seq;
                1:       b = chunk;
                2:       b = enc;
                default: b = 8'($urandom);
            endcase
            send_byte(b, l);
            if (i == 0 && int'(l) >= int'(HDR_BYTES))
            begin
                next_seq = seq + 8'd1;
            end
            if (i + 1 >= eff)
            begin
                break;
            end
            i++;
        end
        idle_on = ($urandom_range(0, 2) != 0);
    endtask

    task automatic wait_all_results();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        wait (pending == 0);
        @(posedge clk);
    endtask

    task automatic set_led_count(input logic [15:0] value);
        wait_all_results();
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we  <= 1'b0;
        led_now = value;
    endtask

    task automatic random_packet();
        int          q;
        int          npix;
        int          switch_at;
        logic [7:0]  seq;
        logic [7:0]  chunk;
        logic [7:0]  enc;
        logic [10:0] len;
        logic [10:0] alt_len;
        q   = int'(led_now) / CHUNK_PIXELS;
        seq = ($urandom_range(0, 9) < 8) ? next_seq : 8'($urandom);
        if ($urandom_range(0, 9) < 7)
            chunk = 8'($urandom_range(0, (q + 1 > 255) ? 255 : q + 1));
        else
            chunk = 8'($urandom);
        enc = ($urandom_range(0, 9) < 8) ? ENC_RGB : 8'($urandom);
        if ($urandom_range(0, 9) < 8)
        begin
            npix = $urandom_range(0, 12);
            len  = 11'(int'(HDR_BYTES) + 3 * npix);
        end
        else
        begin
            len = 11'($urandom_range(0, 40));
        end
        if ($urandom_range(0, 24) == 0)
        begin
            switch_at = $urandom_range(1, 4);
            alt_len   = 11'($urandom_range(0, 12));
        end
        else
        begin
            switch_at = NO_SWITCH;
            alt_len   = len;
        end
        send_packet(seq, chunk, enc, len, alt_len, switch_at);
    endtask

    initial
    begin
        logic [15:0] strip_sizes[7];
        int          phase_end;
        int          half;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        cfg_we        = 1'b0;
        cfg_wdata     = '0;
        quiet         = 1'b0;
        idle_on       = 1'b1;
        hold_request  = 1'b0;
        next_seq      = '0;
        led_now       = LED_COUNT_RESET;
        sent_items    = 0;
        rst_n         = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_packet(8'h00, 8'h00, 8'h00, 11'd0, 11'd0, NO_SWITCH);
        send_packet(8'hFF, 8'h00, 8'h00, 11'd1, 11'd1, NO_SWITCH);
        send_packet(8'h05, 8'h07, 8'h00, 11'd2, 11'd2, NO_SWITCH);
        send_packet(8'h05, 8'h00, ENC_RGB, 11'd6, 11'd6, NO_SWITCH);
        send_packet(8'h09, 8'h01, ENC_RGB, 11'd6, 11'd6, NO_SWITCH);
        send_packet(8'h0A, 8'h00, ENC_RGB, 11'd3, 11'd3, NO_SWITCH);
        send_packet(8'h0B, 8'h00, 8'hFF, 11'd4, 11'd4, NO_SWITCH);
        send_packet(8'h0C, 8'h03, ENC_RGB, 11'd4, 11'd4, NO_SWITCH);
        send_packet(8'h0D, 8'h00, ENC_RGB, 11'd10, 11'd2, 2);

        strip_sizes[0] = 16'd300;
        strip_sizes[1] = 16'd1;
        strip_sizes[2] = 16'd65535;
        strip_sizes[3] = 16'd0;
        strip_sizes[4] = 16'd299;
        strip_sizes[5] = 16'($urandom_range(301, 1200));
        strip_sizes[6] = 16'd900;

        for (int p = 0; p < 7; p++)
        begin
            set_led_count(strip_sizes[p]);
            if (p == 6)
            begin
                quiet = 1'b1;
            end
            if (p == 2)
            begin
                send_packet(next_seq, 8'h00, ENC_RGB, 11'd1473, 11'd4, 3);
                send_packet(next_seq, 8'h00, ENC_RGB, 11'd2047, 11'd7, 3);
                send_packet(next_seq, 8'hDA, ENC_RGB, 11'd450, 11'd450, NO_SWITCH);
            end
            phase_end = sent_items + 180;
            half      = sent_items + 90;
            while (sent_items < phase_end)
            begin
                random_packet();
                if (half > 0 && sent_items >= half)
                begin
                    half = 0;
                    if (p == 1)
                    begin
                        hold_request = 1'b1;
                    end
                    else if (p == 3)
                    begin
                        wait_all_results();
                    end
                end
            end
        end

        wait_all_results();
        repeat (10) @(posedge clk);
        if (failures == 0)
        begin
            $display("SCOREBOARD CLEAN");
        end
        else
        begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
